@@ rtl/gtp_pkg.sv @@
// ----------------------------------------------------------------------------
// gtp_pkg
// shared widths, types and register codes of the goertzel tone power block
// ----------------------------------------------------------------------------
`default_nettype none

package gtp_pkg;

  localparam int ACC_WIDTH      = 48;
  localparam int COEF_FRAC_BITS = 14;

  localparam int SMP_W     = 16;
  localparam int COEF_W    = 16;
  localparam int LEN_W     = 16;
  localparam int OUT_W     = 32;
  localparam int CFG_IDX_W = 2;

  localparam int PROD_W   = ACC_WIDTH + COEF_W;
  localparam int POW_W    = 2 * ACC_WIDTH;
  localparam int DVD_W    = POW_W + 1;
  localparam int DVS_W    = 2 * LEN_W;
  localparam int DIG_N    = (ACC_WIDTH + COEF_W - 1) / COEF_W;
  localparam int DIG_W    = DIG_N * COEF_W;
  localparam int SQ_STEPS = 2 * DIG_N;
  localparam int SQ_CNT_W = $clog2(SQ_STEPS + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLOCK_LENGTH = 2'd0,
    CFG_COS_A        = 2'd1,
    CFG_SIN_A        = 2'd2
  } cfg_idx_e;

  typedef logic signed [ACC_WIDTH-1:0] acc_t;
  typedef logic [ACC_WIDTH-1:0]        acc_mag_t;
  typedef logic [COEF_W-1:0]           coef_mag_t;
  typedef logic [PROD_W-1:0]           prod_t;

  typedef struct packed {
    logic      load;
    logic      neg;
    acc_mag_t  a;
    coef_mag_t b;
  } mul_req_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [OUT_W-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

@@ rtl/gtp_mul.sv @@
// ----------------------------------------------------------------------------
// gtp_mul
// shared unsigned multiplier with registered product and sign tag
// ----------------------------------------------------------------------------
`default_nettype none

module gtp_mul
  import gtp_pkg::*;
(
  input  logic     clk_i,
  input  mul_req_t req_i,
  output prod_t    prod_o,
  output logic     neg_o
);

  prod_t prod_q;
  logic  neg_q;

  always_ff @(posedge clk_i) begin
    if (req_i.load) begin
      prod_q <= prod_t'(req_i.a) * prod_t'(req_i.b);
      neg_q  <= req_i.neg;
    end
  end

  assign prod_o = prod_q;
  assign neg_o  = neg_q;

endmodule

`default_nettype wire

@@ rtl/gtp_div.sv @@
// ----------------------------------------------------------------------------
// gtp_div
// restoring divider, one quotient bit per cycle, saturating quotient
// ----------------------------------------------------------------------------
`default_nettype none

module gtp_div
  import gtp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int HI_W  = DVD_W - OUT_W;
  localparam int CNT_W = $clog2(OUT_W);

  typedef enum logic [2:0] {
    DV_IDLE = 3'b001,
    DV_CHK  = 3'b010,
    DV_RUN  = 3'b100
  } div_state_e;

  div_state_e         state_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               done_q;
  logic [HI_W-1:0]    hi_q;
  logic [OUT_W-1:0]   lo_q;
  logic [DVS_W-1:0]   dvs_q;

  logic [DVS_W:0]     shl;
  logic [DVS_W:0]     dif;
  logic               ge;
  logic               ovf;

  assign shl = {hi_q[DVS_W-1:0], lo_q[OUT_W-1]};
  assign dif = shl - {1'b0, dvs_q};
  assign ge  = shl >= {1'b0, dvs_q};
  assign ovf = hi_q >= HI_W'(dvs_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        DV_IDLE: begin
          if (req_i.start) begin
            state_q <= DV_CHK;
          end
        end
        DV_CHK: begin
          cnt_q <= '0;
          if (ovf) begin
            done_q  <= 1'b1;
            state_q <= DV_IDLE;
          end else begin
            state_q <= DV_RUN;
          end
        end
        DV_RUN: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(OUT_W - 1)) begin
            done_q  <= 1'b1;
            state_q <= DV_IDLE;
          end
        end
        default: state_q <= DV_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      DV_IDLE: begin
        if (req_i.start) begin
          hi_q  <= req_i.dividend[DVD_W-1:OUT_W];
          lo_q  <= req_i.dividend[OUT_W-1:0];
          dvs_q <= req_i.divisor;
        end
      end
      DV_CHK: begin
        // quotient would not fit, also covers a zero divisor
        if (ovf) begin
          lo_q <= '1;
        end
      end
      DV_RUN: begin
        hi_q[DVS_W-1:0] <= ge ? dif[DVS_W-1:0] : shl[DVS_W-1:0];
        lo_q            <= {lo_q[OUT_W-2:0], ge};
      end
      default: ;
    endcase
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = lo_q;

endmodule

`default_nettype wire

@@ rtl/goertzel_tone_power.sv @@
// ----------------------------------------------------------------------------
// goertzel_tone_power
// goertzel tone detector: per-sample recurrence on one shared multiplier,
// twice the power of the final bin divided by N^2 on a serial divider
// ----------------------------------------------------------------------------
// a sample not flagged last returns from acceptance to ready through the steps
// accept with product on the shared multiplier, round, add and subtract
// a last sample runs to its result through the final bin terms, 6 squaring products,
// N^2, then 33 divider steps; the quotient steps are skipped if the quotient saturates
// reset clears both recurrence states and loads N=205, cos=16384, sin=0
// ----------------------------------------------------------------------------
`default_nettype none

module goertzel_tone_power
  import gtp_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic signed [SMP_W-1:0] sample_i,
  input  logic                    last_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  output logic [OUT_W-1:0]        strength_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [COEF_W-1:0]       cfg_data_i
);

  typedef enum logic [10:0] {
    ST_IDLE = 11'h001,
    ST_RND  = 11'h002,
    ST_ADD  = 11'h004,
    ST_SUB  = 11'h008,
    ST_RRE  = 11'h010,
    ST_SRE  = 11'h020,
    ST_RIM  = 11'h040,
    ST_SQR  = 11'h080,
    ST_DIVS = 11'h100,
    ST_DIVW = 11'h200,
    ST_OUT  = 11'h400
  } state_e;

  typedef logic signed [ACC_WIDTH:0] wide_t;

  localparam acc_t  ACC_MAX  = acc_t'({1'b0, {(ACC_WIDTH-1){1'b1}}});
  localparam acc_t  ACC_MIN  = acc_t'({1'b1, {(ACC_WIDTH-1){1'b0}}});
  localparam prod_t HALF_FIN = prod_t'(1) << (COEF_FRAC_BITS - 1);
  localparam prod_t HALF_REC = prod_t'(1) << (COEF_FRAC_BITS - 2);

  function automatic acc_t sat_acc(input wide_t v);
    if (v[ACC_WIDTH] != v[ACC_WIDTH-1]) begin
      return v[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
    end
    return acc_t'(v[ACC_WIDTH-1:0]);
  endfunction

  function automatic acc_mag_t mag(input acc_t v);
    return v[ACC_WIDTH-1] ? acc_mag_t'(-v) : acc_mag_t'(v);
  endfunction

  // round half away from zero on the magnitude, clamp to the positive limit
  function automatic acc_mag_t rnd_mag(input prod_t p, input logic fin);
    prod_t sum;
    prod_t q;
    sum = p + (fin ? HALF_FIN : HALF_REC);
    q   = fin ? (sum >> COEF_FRAC_BITS) : (sum >> (COEF_FRAC_BITS - 1));
    return (q > prod_t'(ACC_MAX)) ? acc_mag_t'(ACC_MAX) : q[ACC_WIDTH-1:0];
  endfunction

  function automatic acc_t apply_sign(input acc_mag_t m, input logic neg);
    return neg ? acc_t'(-m) : acc_t'(m);
  endfunction

  state_e                   state_q, state_d;
  logic [LEN_W-1:0]         blk_len_q;
  logic signed [COEF_W-1:0] cos_q, sin_q;
  acc_t                     s1_q, s2_q;
  acc_mag_t                 s1_mag_q;
  logic [SQ_CNT_W-1:0]      sq_cnt_q;
  logic                     out_valid_q;

  logic signed [SMP_W-1:0]  x_q;
  logic                     last_q;
  acc_t                     p_q, t_q, re_q;
  acc_mag_t                 re_mag_q, im_mag_q;
  logic [DIG_W-1:0]         re_dig_q, im_dig_q;
  logic [POW_W-1:0]         pw_q;
  logic [OUT_W-1:0]         res_q, strength_q;

  logic      in_accept;
  logic      out_free;
  logic      sq_end;
  coef_mag_t cos_mag, sin_mag;
  acc_t      s0_c;
  acc_mag_t  re_mag_c, im_mag_c;
  mul_req_t  mreq;
  prod_t     prod;
  logic      mul_neg;
  div_req_t  dreq;
  div_rsp_t  drsp;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_accept   = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign strength_o  = strength_q;
  assign sq_end      = (sq_cnt_q == SQ_CNT_W'(SQ_STEPS));

  assign cos_mag  = cos_q[COEF_W-1] ? coef_mag_t'(-cos_q) : coef_mag_t'(cos_q);
  assign sin_mag  = sin_q[COEF_W-1] ? coef_mag_t'(-sin_q) : coef_mag_t'(sin_q);
  assign s0_c     = sat_acc(wide_t'(t_q) - wide_t'(s2_q));
  assign re_mag_c = mag(re_q);
  assign im_mag_c = rnd_mag(prod, 1'b1);

  // shared multiplier operand select
  always_comb begin
    mreq.load = 1'b0;
    mreq.neg  = s1_q[ACC_WIDTH-1] ^ cos_q[COEF_W-1];
    mreq.a    = s1_mag_q;
    mreq.b    = cos_mag;
    unique case (state_q)
      ST_IDLE: mreq.load = in_accept;
      ST_RRE: begin
        mreq.load = 1'b1;
        mreq.neg  = s1_q[ACC_WIDTH-1] ^ sin_q[COEF_W-1];
        mreq.b    = sin_mag;
      end
      ST_SQR: begin
        mreq.load = 1'b1;
        if (sq_end) begin
          mreq.a = acc_mag_t'(blk_len_q);
          mreq.b = coef_mag_t'(blk_len_q);
        end else if (sq_cnt_q[0]) begin
          mreq.a = im_mag_q;
          mreq.b = im_dig_q[DIG_W-1 -: COEF_W];
        end else begin
          mreq.a = re_mag_q;
          mreq.b = re_dig_q[DIG_W-1 -: COEF_W];
        end
      end
      ST_RND, ST_ADD, ST_SUB, ST_SRE, ST_RIM, ST_DIVS, ST_DIVW, ST_OUT: ;
      default: ;
    endcase
  end

  gtp_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mreq),
    .prod_o (prod),
    .neg_o  (mul_neg)
  );

  assign dreq.start    = (state_q == ST_DIVS);
  assign dreq.dividend = {pw_q, 1'b0};
  assign dreq.divisor  = prod[DVS_W-1:0];

  gtp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_accept) state_d = ST_RND;
      ST_RND:  state_d = ST_ADD;
      ST_ADD:  state_d = ST_SUB;
      ST_SUB:  state_d = last_q ? ST_RRE : ST_IDLE;
      ST_RRE:  state_d = ST_SRE;
      ST_SRE:  state_d = ST_RIM;
      ST_RIM:  state_d = ST_SQR;
      ST_SQR:  if (sq_end) state_d = ST_DIVS;
      ST_DIVS: state_d = ST_DIVW;
      ST_DIVW: if (drsp.done) state_d = ST_OUT;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      blk_len_q   <= LEN_W'(205);
      cos_q       <= COEF_W'(16384);
      sin_q       <= '0;
      s1_q        <= '0;
      s2_q        <= '0;
      s1_mag_q    <= '0;
      sq_cnt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_BLOCK_LENGTH: blk_len_q <= cfg_data_i;
          CFG_COS_A:        cos_q     <= cfg_data_i;
          CFG_SIN_A:        sin_q     <= cfg_data_i;
          default: ;
        endcase
      end

      if (state_q == ST_SUB && !last_q) begin
        s2_q     <= s1_q;
        s1_q     <= s0_c;
        s1_mag_q <= mag(s0_c);
      end else if (state_q == ST_OUT && out_free) begin
        s1_q     <= '0;
        s2_q     <= '0;
        s1_mag_q <= '0;
      end

      if (state_q == ST_RIM) begin
        sq_cnt_q <= '0;
      end else if (state_q == ST_SQR) begin
        sq_cnt_q <= sq_cnt_q + 1'b1;
      end

      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      x_q    <= sample_i;
      last_q <= last_i;
    end
    unique case (state_q)
      ST_RND: p_q <= apply_sign(rnd_mag(prod, 1'b0), mul_neg);
      ST_ADD: t_q <= sat_acc(wide_t'(x_q) + wide_t'(p_q));
      ST_SUB: re_q <= s0_c;
      ST_RRE: p_q <= apply_sign(rnd_mag(prod, 1'b1), mul_neg);
      ST_SRE: re_q <= sat_acc(wide_t'(re_q) - wide_t'(p_q));
      ST_RIM: begin
        re_mag_q <= re_mag_c;
        im_mag_q <= im_mag_c;
        re_dig_q <= DIG_W'(re_mag_c);
        im_dig_q <= DIG_W'(im_mag_c);
        pw_q     <= '0;
      end
      ST_SQR: begin
        // horner over digits: shift before each re product, plain add for im
        if (!sq_end) begin
          if (sq_cnt_q[0]) begin
            im_dig_q <= im_dig_q << COEF_W;
          end else begin
            re_dig_q <= re_dig_q << COEF_W;
          end
        end
        if (sq_cnt_q != '0) begin
          if (sq_cnt_q[0]) begin
            pw_q <= (pw_q << COEF_W) + POW_W'(prod);
          end else begin
            pw_q <= pw_q + POW_W'(prod);
          end
        end
      end
      ST_DIVW: if (drsp.done) res_q <= drsp.quot;
      ST_OUT:  if (out_free) strength_q <= res_q;
      ST_IDLE, ST_DIVS: ;
      default: ;
    endcase
  end

  a_state_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUB && !last_q) |=> (s2_q == $past(s1_q)))
    else $error("recurrence state did not shift");

  a_mag_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_mag_q == mag(s1_q))
    else $error("stored magnitude out of step with state");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drsp.done |-> (state_q == ST_DIVW))
    else $error("divider finished outside its wait state");

  a_block_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && out_free) |=> (s1_q == '0 && s2_q == '0 && out_valid_o))
    else $error("block end did not clear state or post the transaction");

endmodule

`default_nettype wire
